[src/lpg_pkg.sv]
// Shared types and command codes for the line pixel generator.
package lpg_pkg;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    typedef struct packed {
        logic full;
        logic empty;
    } lpg_qstat_t;

endpackage

[src/lpg_front.sv]
// Front end: classifies an incoming item and precomputes line setup for loads.
module lpg_front #(
    parameter int COORD_BITS = 12
) (
    input  logic                           command,
    input  logic signed [COORD_BITS-1:0]   x_start,
    input  logic signed [COORD_BITS-1:0]   y_start,
    input  logic signed [COORD_BITS-1:0]   x_end,
    input  logic signed [COORD_BITS-1:0]   y_end,
    output logic [5*COORD_BITS+6:0]        entry
);
    localparam int TERM_BITS = COORD_BITS + 3;

    logic signed [COORD_BITS:0]   diff_x;
    logic signed [COORD_BITS:0]   diff_y;
    logic [COORD_BITS:0]          abs_x;
    logic [COORD_BITS:0]          abs_y;
    logic [COORD_BITS-1:0]        dx;
    logic [COORD_BITS-1:0]        dy;
    logic [COORD_BITS-1:0]        major;
    logic [COORD_BITS-1:0]        minor;
    logic                         steep;
    logic                         x_inc;
    logic                         y_inc;
    logic [TERM_BITS-1:0]         term;

    always_comb
    begin
        diff_x = {x_end[COORD_BITS-1], x_end} - {x_start[COORD_BITS-1], x_start};
        diff_y = {y_end[COORD_BITS-1], y_end} - {y_start[COORD_BITS-1], y_start};
        abs_x  = diff_x[COORD_BITS] ? (-diff_x) : diff_x;
        abs_y  = diff_y[COORD_BITS] ? (-diff_y) : diff_y;
        dx     = abs_x[COORD_BITS-1:0];
        dy     = abs_y[COORD_BITS-1:0];
        x_inc  = !diff_x[COORD_BITS] && (diff_x != '0);
        y_inc  = !diff_y[COORD_BITS] && (diff_y != '0);
        steep  = dy > dx;
        major  = steep ? dy : dx;
        minor  = steep ? dx : dy;
        // initial decision term: 2*minor - major
        term   = {2'b00, minor, 1'b0} - {3'b000, major};
        entry  = {command, x_start, y_start, major, minor, steep, x_inc, y_inc, term};
    end

endmodule

[src/lpg_queue.sv]
// Two-entry queue that decouples the front end from the pixel stepper.
module lpg_queue #(
    parameter int WIDTH = 67
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic                 pop,
    output logic [WIDTH-1:0]     rd_data,
    output lpg_pkg::lpg_qstat_t  status
);
    import lpg_pkg::*;

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
        status.full  = count_reg == 2'd2;
        status.empty = count_reg == 2'd0;
        rd_data      = mem_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[src/lpg_back.sv]
// Back end: holds the line state, loads a line or steps one pixel per item, registers the result.
module lpg_back #(
    parameter int COORD_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [5*COORD_BITS+6:0]       entry,
    input  lpg_pkg::lpg_qstat_t           qstat,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_BITS-1:0]  pixel_x,
    output logic signed [COORD_BITS-1:0]  pixel_y,
    output logic                          pixel_valid,
    output logic                          last_pixel
);
    import lpg_pkg::*;

    localparam int TERM_BITS = COORD_BITS + 3;

    logic                  e_cmd;
    logic [COORD_BITS-1:0] e_xs;
    logic [COORD_BITS-1:0] e_ys;
    logic [COORD_BITS-1:0] e_major;
    logic [COORD_BITS-1:0] e_minor;
    logic                  e_steep;
    logic                  e_xinc;
    logic                  e_yinc;
    logic [TERM_BITS-1:0]  e_term;

    logic [COORD_BITS-1:0] x_reg, x_next;
    logic [COORD_BITS-1:0] y_reg, y_next;
    logic [COORD_BITS-1:0] steps_reg, steps_next;
    logic [TERM_BITS-1:0]  term_reg, term_next;
    logic [COORD_BITS-1:0] major_reg, major_next;
    logic [COORD_BITS-1:0] minor_reg, minor_next;
    logic                  steep_reg, steep_next;
    logic                  xinc_reg, xinc_next;
    logic                  yinc_reg, yinc_next;
    logic                  active_reg, active_next;

    logic                  out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0] pixel_x_reg, pixel_x_next;
    logic [COORD_BITS-1:0] pixel_y_reg, pixel_y_next;
    logic                  pixel_valid_reg, pixel_valid_next;
    logic                  last_pixel_reg, last_pixel_next;

    logic                  nonneg;
    logic                  move_x;
    logic                  move_y;
    logic [TERM_BITS-1:0]  minor2;
    logic [TERM_BITS-1:0]  major2;
    logic [COORD_BITS-1:0] x_delta;
    logic [COORD_BITS-1:0] y_delta;

    always_comb
    begin
        {e_cmd, e_xs, e_ys, e_major, e_minor, e_steep, e_xinc, e_yinc, e_term} = entry;

        pop = !qstat.empty && (!out_valid_reg || out_ready);

        nonneg  = !term_reg[TERM_BITS-1];
        move_x  = !steep_reg || nonneg;
        move_y  = steep_reg || nonneg;
        minor2  = {2'b00, minor_reg, 1'b0};
        major2  = {2'b00, major_reg, 1'b0};
        x_delta = xinc_reg ? {{(COORD_BITS-1){1'b0}}, 1'b1} : {COORD_BITS{1'b1}};
        y_delta = yinc_reg ? {{(COORD_BITS-1){1'b0}}, 1'b1} : {COORD_BITS{1'b1}};

        x_next      = x_reg;
        y_next      = y_reg;
        steps_next  = steps_reg;
        term_next   = term_reg;
        major_next  = major_reg;
        minor_next  = minor_reg;
        steep_next  = steep_reg;
        xinc_next   = xinc_reg;
        yinc_next   = yinc_reg;
        active_next = active_reg;

        out_valid_next   = out_valid_reg && !out_ready;
        pixel_x_next     = pixel_x_reg;
        pixel_y_next     = pixel_y_reg;
        pixel_valid_next = pixel_valid_reg;
        last_pixel_next  = last_pixel_reg;

        if (pop)
        begin
            out_valid_next = 1'b1;
            if (e_cmd == CMD_LOAD)
            begin
                // drop any line in flight and start the new one
                x_next      = e_xs;
                y_next      = e_ys;
                steps_next  = e_major;
                term_next   = e_term;
                major_next  = e_major;
                minor_next  = e_minor;
                steep_next  = e_steep;
                xinc_next   = e_xinc;
                yinc_next   = e_yinc;
                active_next = e_major != '0;
                pixel_x_next     = e_xs;
                pixel_y_next     = e_ys;
                pixel_valid_next = 1'b1;
                last_pixel_next  = e_major == '0;
            end
            else if (!active_reg)
            begin
                pixel_x_next     = '0;
                pixel_y_next     = '0;
                pixel_valid_next = 1'b0;
                last_pixel_next  = 1'b0;
            end
            else
            begin
                term_next   = nonneg ? (term_reg + minor2 - major2) : (term_reg + minor2);
                x_next      = move_x ? (x_reg + x_delta) : x_reg;
                y_next      = move_y ? (y_reg + y_delta) : y_reg;
                steps_next  = steps_reg - {{(COORD_BITS-1){1'b0}}, 1'b1};
                active_next = steps_next != '0;
                pixel_x_next     = x_next;
                pixel_y_next     = y_next;
                pixel_valid_next = 1'b1;
                last_pixel_next  = steps_next == '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg           <= '0;
            y_reg           <= '0;
            steps_reg       <= '0;
            term_reg        <= '0;
            major_reg       <= '0;
            minor_reg       <= '0;
            steep_reg       <= 1'b0;
            xinc_reg        <= 1'b0;
            yinc_reg        <= 1'b0;
            active_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
            pixel_x_reg     <= '0;
            pixel_y_reg     <= '0;
            pixel_valid_reg <= 1'b0;
            last_pixel_reg  <= 1'b0;
        end
        else
        begin
            x_reg           <= x_next;
            y_reg           <= y_next;
            steps_reg       <= steps_next;
            term_reg        <= term_next;
            major_reg       <= major_next;
            minor_reg       <= minor_next;
            steep_reg       <= steep_next;
            xinc_reg        <= xinc_next;
            yinc_reg        <= yinc_next;
            active_reg      <= active_next;
            out_valid_reg   <= out_valid_next;
            pixel_x_reg     <= pixel_x_next;
            pixel_y_reg     <= pixel_y_next;
            pixel_valid_reg <= pixel_valid_next;
            last_pixel_reg  <= last_pixel_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign pixel_valid = pixel_valid_reg;
    assign last_pixel  = last_pixel_reg;

`ifndef ASSERT_OFF
    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (last_pixel_reg == (pixel_valid_reg && !active_reg)))
        else $error("last pixel flag disagrees with line state");

    a_active_has_steps: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (steps_reg != '0))
        else $error("active line with no steps left");

    a_idle_step_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pixel_valid_reg) |->
            (pixel_x_reg == '0 && pixel_y_reg == '0 && !last_pixel_reg))
        else $error("idle step result is not all zero");
`endif

endmodule

[src/line_pixel_generator.sv]
// Top level of the line pixel generator: front end, item queue and pixel stepper.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------
//   input   | in_valid / in_ready  | command, x_start, y_start, x_end, y_end
//   output  | out_valid / out_ready| pixel_x, pixel_y, pixel_valid, last_pixel
//
// One item per clock sustained while out_ready stays high; the stepper's single add-and-compare per item sets it.
// A result goes valid once its input item has passed through the queue and then the output register.
// in_ready drops only when the two-entry queue is full.
// Reset clears the line state to idle and empties the queue.
// An output stall backs up into the queue before it reaches in_ready.
module line_pixel_generator #(
    parameter int COORD_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          command,
    input  logic signed [COORD_BITS-1:0]  x_start,
    input  logic signed [COORD_BITS-1:0]  y_start,
    input  logic signed [COORD_BITS-1:0]  x_end,
    input  logic signed [COORD_BITS-1:0]  y_end,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_BITS-1:0]  pixel_x,
    output logic signed [COORD_BITS-1:0]  pixel_y,
    output logic                          pixel_valid,
    output logic                          last_pixel
);
    import lpg_pkg::*;

    localparam int ENTRY_W = 5 * COORD_BITS + 7;

    logic [ENTRY_W-1:0] front_entry;
    logic [ENTRY_W-1:0] queue_entry;
    lpg_qstat_t         qstat;
    logic               push;
    logic               pop;

    assign in_ready = !qstat.full;
    assign push     = in_valid && in_ready;

    lpg_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .command (command),
        .x_start (x_start),
        .y_start (y_start),
        .x_end   (x_end),
        .y_end   (y_end),
        .entry   (front_entry)
    );

    lpg_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (front_entry),
        .pop     (pop),
        .rd_data (queue_entry),
        .status  (qstat)
    );

    lpg_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry       (queue_entry),
        .qstat       (qstat),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_valid (pixel_valid),
        .last_pixel  (last_pixel)
    );

endmodule
